FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and codes for the card deque
// Card field widths, op and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   localparam int RANK_W    = 4;
   localparam int SUIT_W    = 2;
   localparam int CARD_W    = RANK_W + SUIT_W;
   localparam int OP_W      = 3;
   localparam int ST_W      = 2;
   localparam int OUT_CNT_W = 7;

   // Operation codes carried by a request word.
   localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
   localparam logic [OP_W-1:0] OP_POP    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;

   // Status codes returned in every response word.
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
   localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

   // Which slot a memory write goes to.
   typedef enum logic [1:0] {
      WR_BACK,
      WR_FRONT,
      WR_IDX
   } wr_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            latch_req;
      logic            mem_rd;
      logic            rd_next;
      logic            mem_wr;
      wr_sel_type      wr_sel;
      logic            wr_from_mem;
      logic            head_inc;
      logic            head_dec;
      logic            total_inc;
      logic            total_dec;
      logic            idx_inc;
      logic            set_status;
      logic [ST_W-1:0] status_code;
      logic            load_pop;
      logic            tally_inc;
      logic            load_result;
   } cdq_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            idx_last;
      logic            idx_penult;
      logic            key_match;
      logic            suit_match;
      logic            rsp_free;
   } cdq_sts_type;

endpackage

`default_nettype wire

FILE: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: card storage, pointers and response register
// Holds the cards in a circular buffer memory with a head pointer and a
// length, walks an index for search and shift, and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_datapath #(
   parameter int DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire cdq_pkg::cdq_cmd_type            cmd,
   output cdq_pkg::cdq_sts_type                 sts,
   input  wire logic [cdq_pkg::OP_W-1:0]        req_op,
   input  wire logic [cdq_pkg::RANK_W-1:0]      req_card_rank,
   input  wire logic [cdq_pkg::SUIT_W-1:0]      req_card_suit,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_valid,
   output logic [cdq_pkg::ST_W-1:0]             rsp_status,
   output logic [cdq_pkg::RANK_W-1:0]           rsp_popped_rank,
   output logic [cdq_pkg::SUIT_W-1:0]           rsp_pop_suit,
   output logic [cdq_pkg::OUT_CNT_W-1:0]        rsp_suit_tally,
   output logic [cdq_pkg::OUT_CNT_W-1:0]        rsp_length_now
);
   import cdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Maps a logical position to a memory address, wrapping past the end.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [CARD_W-1:0] mem [DEPTH];
   logic [CARD_W-1:0] rd_data_ff;

   logic [OP_W-1:0]   op_ff;
   logic [CARD_W-1:0] key_ff;
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     tally_ff;
   logic [ST_W-1:0]   status_ff;
   logic [CARD_W-1:0] pop_ff;

   logic              rsp_valid_ff;
   logic [ST_W-1:0]   rsp_status_ff;
   logic [CARD_W-1:0] rsp_pop_ff;
   logic [OUT_CNT_W-1:0] rsp_tally_ff;
   logic [OUT_CNT_W-1:0] rsp_len_ff;

   logic [AW-1:0]     idx_plus;
   logic [CW:0]       idx_w;
   logic [AW-1:0]     head_minus;
   logic [AW-1:0]     head_plus;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [CARD_W-1:0] wr_data;

   // Neighbor positions of the index and the head.
   assign idx_plus   = idx_ff + AW'(1);
   assign idx_w      = (CW+1)'(idx_ff);
   assign head_minus = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_plus  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // Memory addresses and write data.
   assign rd_addr = phys(head_ff, cmd.rd_next ? idx_plus : idx_ff);
   assign wr_data = cmd.wr_from_mem ? rd_data_ff : key_ff;

   always_comb begin
      case (cmd.wr_sel)
         WR_BACK:  wr_addr = phys(head_ff, total_ff[AW-1:0]);
         WR_FRONT: wr_addr = head_minus;
         WR_IDX:   wr_addr = phys(head_ff, idx_ff);
         default:  wr_addr = phys(head_ff, idx_ff);
      endcase
   end

   // Card memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Next values of the pointers.
   always_comb begin
      head_in = head_ff;
      if (cmd.head_inc) begin
         head_in = head_plus;
      end else if (cmd.head_dec) begin
         head_in = head_minus;
      end
      total_in = total_ff;
      if (cmd.total_inc) begin
         total_in = total_ff + CW'(1);
      end else if (cmd.total_dec) begin
         total_in = total_ff - CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.latch_req) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_plus;
      end
   end

   // Pointer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         total_ff <= '0;
         idx_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         total_ff <= total_in;
         idx_ff   <= idx_in;
      end
   end

   // Per-request working registers.
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         op_ff     <= req_op;
         key_ff    <= {req_card_rank, req_card_suit};
         status_ff <= ST_OK;
         pop_ff    <= '0;
         tally_ff  <= '0;
      end else begin
         if (cmd.set_status) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.load_pop) begin
            pop_ff <= rd_data_ff;
         end
         if (cmd.tally_inc) begin
            tally_ff <= tally_ff + CW'(1);
         end
      end
   end

   // Response register; it frees as the consumer takes the word.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_status_ff <= status_ff;
         rsp_pop_ff    <= pop_ff;
         rsp_tally_ff  <= OUT_CNT_W'(tally_ff);
         rsp_len_ff    <= OUT_CNT_W'(total_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_popped_rank = rsp_pop_ff[CARD_W-1:SUIT_W];
   assign rsp_pop_suit    = rsp_pop_ff[SUIT_W-1:0];
   assign rsp_suit_tally  = rsp_tally_ff;
   assign rsp_length_now  = rsp_len_ff;

   // Status for the controller.
   always_comb begin
      sts.op         = op_ff;
      sts.full       = (total_ff == CW'(DEPTH));
      sts.empty      = (total_ff == '0);
      sts.idx_last   = ((idx_w + (CW+1)'(1)) == {1'b0, total_ff});
      sts.idx_penult = ((idx_w + (CW+1)'(2)) == {1'b0, total_ff});
      sts.key_match  = (rd_data_ff == key_ff);
      sts.suit_match = (rd_data_ff[SUIT_W-1:0] == key_ff[SUIT_W-1:0]);
      sts.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(DEPTH))
      else $error("card count exceeds depth");

   a_grow_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.total_inc |-> !sts.full)
      else $error("card added to a full store");

   a_shrink_not_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.total_dec |-> !sts.empty)
      else $error("card taken from an empty store");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> rsp_valid_ff)
      else $error("loaded response not presented");

endmodule

`default_nettype wire

FILE: rtl/cdq_controller.sv
// ----------------------------------------------------------------------------
// cdq_controller: sequencer for the card deque
// Accepts one request word, steps the datapath through the operation, and
// hands the finished response to the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cdq_pkg::cdq_sts_type sts,
   output cdq_pkg::cdq_cmd_type  cmd
);
   import cdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_DATA,
      S_REM_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_CNT_CHK,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Command decode and next state.
   always_comb begin
      cmd         = '0;
      cmd.wr_sel  = WR_BACK;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (sts.op)
               OP_APPEND: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.wr_sel    = WR_BACK;
                     cmd.total_inc = 1'b1;
                  end
               end
               OP_PUSH: begin
                  if (sts.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.mem_wr    = 1'b1;
                     cmd.wr_sel    = WR_FRONT;
                     cmd.head_dec  = 1'b1;
                     cmd.total_inc = 1'b1;
                  end
               end
               OP_POP: begin
                  if (sts.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EMPTY;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_POP_DATA;
                  end
               end
               OP_REMOVE: begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_MISSING;
                  if (!sts.empty) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_REM_CHK;
                  end
               end
               OP_COUNT: begin
                  if (!sts.empty) begin
                     cmd.mem_rd = 1'b1;
                     state_in   = S_CNT_CHK;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_POP_DATA: begin
            cmd.load_pop  = 1'b1;
            cmd.head_inc  = 1'b1;
            cmd.total_dec = 1'b1;
            state_in      = S_FINISH;
         end
         // One stored card a cycle is compared against the key.
         S_REM_CHK: begin
            if (sts.key_match) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_OK;
               if (sts.idx_last) begin
                  cmd.total_dec = 1'b1;
                  state_in      = S_FINISH;
               end else begin
                  cmd.mem_rd  = 1'b1;
                  cmd.rd_next = 1'b1;
                  state_in    = S_SHIFT_WR;
               end
            end else if (sts.idx_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.mem_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.mem_rd  = 1'b1;
            cmd.rd_next = 1'b1;
            state_in    = S_SHIFT_WR;
         end
         // Close the gap: the card behind moves one place forward.
         S_SHIFT_WR: begin
            cmd.mem_wr      = 1'b1;
            cmd.wr_sel      = WR_IDX;
            cmd.wr_from_mem = 1'b1;
            cmd.idx_inc     = 1'b1;
            if (sts.idx_penult) begin
               cmd.total_dec = 1'b1;
               state_in      = S_FINISH;
            end else begin
               state_in = S_SHIFT_RD;
            end
         end
         S_CNT_CHK: begin
            cmd.tally_inc = sts.suit_match;
            if (sts.idx_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.mem_rd  = 1'b1;
               cmd.rd_next = 1'b1;
               cmd.idx_inc = 1'b1;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_result = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/card_deque_with_remove_and_count.sv
// Append, push, unused ops and empty-store cases go from the execute state straight to the
// finish state; pop reads the front card first, and count reads one card a cycle over the length.
// Remove compares one card a cycle up to the first match, then shifts each card behind it
// one place forward through a read state and a write state; with no match it reads the whole length.
// Throughput: one request in work at a time; the next is accepted the cycle after the
// response loads. Reset clears length, head, controller and response valid, not the memory.
// ----------------------------------------------------------------------------
// card_deque_with_remove_and_count: bounded card deque with delete by key
// Append, push, pop, remove of the first matching card, and suit count over
// a circular buffer memory, driven by a controller and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module card_deque_with_remove_and_count #(
   parameter int DEPTH = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [cdq_pkg::OP_W-1:0]        req_op,
   input  wire logic [cdq_pkg::RANK_W-1:0]      req_card_rank,
   input  wire logic [cdq_pkg::SUIT_W-1:0]      req_card_suit,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [cdq_pkg::ST_W-1:0]             rsp_status,
   output logic [cdq_pkg::RANK_W-1:0]           rsp_popped_rank,
   output logic [cdq_pkg::SUIT_W-1:0]           rsp_pop_suit,
   output logic [cdq_pkg::OUT_CNT_W-1:0]        rsp_suit_tally,
   output logic [cdq_pkg::OUT_CNT_W-1:0]        rsp_length_now
);
   import cdq_pkg::*;

   cdq_cmd_type cmd;
   cdq_sts_type sts;

   cdq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_op),
      .req_card_rank   (req_card_rank),
      .req_card_suit   (req_card_suit),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_popped_rank (rsp_popped_rank),
      .rsp_pop_suit    (rsp_pop_suit),
      .rsp_suit_tally  (rsp_suit_tally),
      .rsp_length_now  (rsp_length_now)
   );

endmodule

`default_nettype wire
